>>> hw/rtl/platoon_following_accel_law_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the platoon following acceleration law block
// Shared property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef PLATOON_FOLLOWING_ACCEL_LAW_ASSERT_SVH
`define PLATOON_FOLLOWING_ACCEL_LAW_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PFAL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pfal port check failed");

// Check a property on every clock edge, reset included.
`define PFAL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pfal port check failed");

`endif

>>> hw/rtl/pfal_pkg.sv
// ---------------------------------------------------------------------------
// pfal_pkg
// Types and constants shared by the platoon following acceleration law block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfal_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DESIRED_GAP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ACCEL_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DECEL_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN_ACCEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN_SPEED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN_GAP    = 3'd5;

    typedef struct packed {
        logic [11:0] leader_speed_code;
        logic [11:0] follower_speed_code;
        logic [8:0]  leader_accel_code;
        logic [15:0] gap_cm;
        logic [13:0] leader_brake_code;
        logic [13:0] leader_throttle_code;
    } t_in_item;

    typedef struct packed {
        logic [8:0] accel_command_code;
        logic       limited;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        desired_gap_cm;
        logic signed [14:0] accel_limit_milli;
        logic signed [14:0] decel_limit_milli;
        logic [15:0]        gain_leader_accel;
        logic [15:0]        gain_speed_diff;
        logic [15:0]        gain_gap_error;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        desired_gap_cm:    16'd1500,
        accel_limit_milli: 15'sd1500,
        decel_limit_milli: -15'sd5000,
        gain_leader_accel: 16'd6554,
        gain_speed_diff:   16'd3277,
        gain_gap_error:    16'd3277
    };

    typedef enum logic [1:0] {
        FF_NONE,
        FF_SUB,
        FF_ADD
    } t_ff_op;

    // Products of the gains with the differences, plus the pedal term.
    typedef struct packed {
        logic signed [26:0] pa;
        logic signed [29:0] pv;
        logic signed [33:0] pd;
        logic               inner;
        t_ff_op             ff_op;
        logic [28:0]        ffq;
    } t_front;

    typedef struct packed {
        logic signed [29:0] acc0;
        logic [19:0]        ff;
        t_ff_op             ff_op;
    } t_scale;

    localparam logic signed [9:0]  ACCEL_CODE_OFFSET = 10'sd150;
    localparam logic signed [16:0] BAND_HI_CM        = 17'sd1000;
    localparam logic signed [16:0] BAND_LO_CM        = -17'sd500;

    localparam logic [13:0] BRAKE_ON   = 14'd20;
    localparam logic [13:0] PEDAL_KNEE = 14'd1000;
    localparam logic [13:0] BRAKE_FULL = 14'd5000;

    localparam logic [15:0] BRAKE_CURVE_OFS = 16'd15000;
    localparam logic [15:0] BRAKE_LIN_MUL   = 16'd25000;
    localparam logic [15:0] THROTTLE_OFS    = 16'd10000;

    // ceil(2^36 / 25)
    localparam logic [31:0] DIV25_RECIP = 32'd2748779070;
    // ceil(2^69 / 10^9), split in two 20-bit halves
    localparam logic [19:0] FF_RECIP_HI = 20'd562949;
    localparam logic [19:0] FF_RECIP_LO = 20'd999735;
    // ceil(2^22 / 100)
    localparam logic [31:0] DIV100_RECIP = 32'd41944;

    localparam logic signed [35:0] ACC_OFFSET_Q = 36'sd983040;
    localparam logic signed [15:0] MILLI_OFFSET = 16'sd15000;
    localparam logic [8:0]         CODE_MAX     = 9'd300;

endpackage

`default_nettype wire

>>> hw/rtl/pfal_front.sv
// ---------------------------------------------------------------------------
// pfal_front
// First stage: differences, gain products, band select and pedal product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfal_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfal_pkg::t_cfg     i_cfg,
    input  logic               i_vld,
    output logic               o_rdy,
    input  pfal_pkg::t_in_item i_item,
    output logic               o_vld,
    input  logic               i_rdy,
    output pfal_pkg::t_front   o_front
);
    import pfal_pkg::*;

    logic              r_vld;
    t_front            r_front;
    t_front            n_front;
    logic signed [9:0] n_da;
    logic signed [12:0] n_dv;
    logic signed [16:0] n_de;
    logic [13:0]       n_ped;
    logic [15:0]       n_mul;
    logic              w_rdy;

    assign w_rdy = !r_vld || i_rdy;

    always_comb begin
        n_da = $signed({1'b0, i_item.leader_accel_code}) - ACCEL_CODE_OFFSET;
        n_dv = $signed({1'b0, i_item.leader_speed_code})
             - $signed({1'b0, i_item.follower_speed_code});
        n_de = $signed({1'b0, i_item.gap_cm}) - $signed({1'b0, i_cfg.desired_gap_cm});

        n_front.pa    = 27'($signed({1'b0, i_cfg.gain_leader_accel}) * n_da);
        n_front.pv    = 30'($signed({1'b0, i_cfg.gain_speed_diff}) * n_dv);
        n_front.pd    = 34'($signed({1'b0, i_cfg.gain_gap_error}) * n_de);
        n_front.inner = (n_de < BAND_HI_CM) && (n_de > BAND_LO_CM);

        priority if (i_item.leader_brake_code > BRAKE_ON) begin
            if ((i_item.leader_brake_code > PEDAL_KNEE) &&
                (i_item.leader_brake_code < BRAKE_FULL)) begin
                n_front.ff_op = FF_SUB;
                n_ped         = i_item.leader_brake_code;
                n_mul         = {1'b0, i_item.leader_brake_code, 1'b0} + BRAKE_CURVE_OFS;
            end else if (i_item.leader_brake_code >= BRAKE_FULL) begin
                n_front.ff_op = FF_SUB;
                n_ped         = i_item.leader_brake_code;
                n_mul         = BRAKE_LIN_MUL;
            end else begin
                n_front.ff_op = FF_NONE;
                n_ped         = '0;
                n_mul         = '0;
            end
        end else if (i_item.leader_throttle_code > PEDAL_KNEE) begin
            n_front.ff_op = FF_ADD;
            n_ped         = i_item.leader_throttle_code;
            n_mul         = {2'b0, i_item.leader_throttle_code} + THROTTLE_OFS;
        end else begin
            n_front.ff_op = FF_NONE;
            n_ped         = '0;
            n_mul         = '0;
        end

        n_front.ffq = 29'({16'b0, n_ped} * {14'b0, n_mul});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_front <= n_front;
        end
    end

    assign o_rdy   = w_rdy;
    assign o_vld   = r_vld;
    assign o_front = r_front;

endmodule

`default_nettype wire

>>> hw/rtl/pfal_scale.sv
// ---------------------------------------------------------------------------
// pfal_scale
// Stages two to four: band-weighted sum, floor division by 100 through a
// reciprocal, demand scaling and pedal feedforward in Q15.16.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfal_scale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  pfal_pkg::t_front i_front,
    output logic             o_vld,
    input  logic             i_rdy,
    output pfal_pkg::t_scale o_scale
);
    import pfal_pkg::*;

    logic        r_s2_vld;
    logic [31:0] r_s2_y;
    logic        r_s2_neg;
    logic [30:0] r_s2_yff;
    t_ff_op      r_s2_op;

    logic        r_s3_vld;
    logic [26:0] r_s3_q;
    logic        r_s3_neg;
    logic [50:0] r_s3_pl;
    logic [50:0] r_s3_ph;
    t_ff_op      r_s3_op;

    logic        r_s4_vld;
    t_scale      r_s4;

    logic               w_rdy2;
    logic               w_rdy3;
    logic               w_rdy4;

    logic signed [30:0] n_s;
    logic signed [34:0] n_s35;
    logic signed [34:0] n_pd35;
    logic signed [34:0] n_n;
    logic               n_neg;
    logic [34:0]        n_u;
    logic [30:0]        n_yff;
    logic [63:0]        n_prod;
    logic [50:0]        n_pl;
    logic [50:0]        n_ph;
    logic [70:0]        n_ffsum;
    logic signed [27:0] n_base;
    t_scale             n_s4;

    assign w_rdy4 = !r_s4_vld || i_rdy;
    assign w_rdy3 = !r_s3_vld || w_rdy4;
    assign w_rdy2 = !r_s2_vld || w_rdy3;

    // stage 2: weighted sum, fold sign for the unsigned divide
    always_comb begin
        n_s    = 31'(i_front.pa) + 31'(i_front.pv);
        n_s35  = 35'(n_s);
        n_pd35 = 35'(i_front.pd);
        if (i_front.inner) begin
            n_n = (n_s35 <<< 3) + (n_s35 <<< 1) + n_pd35;
        end else begin
            n_n = (n_s35 <<< 2) + n_s35 + (n_pd35 <<< 1);
        end
        n_neg = n_n[34];
        n_u   = n_n ^ {35{n_neg}};
        n_yff = {2'b0, i_front.ffq} + {1'b0, i_front.ffq, 1'b0};
    end

    // stage 3: reciprocal multiplies
    always_comb begin
        n_prod = {32'b0, r_s2_y} * {32'b0, DIV25_RECIP};
        n_pl   = {20'b0, r_s2_yff} * {31'b0, FF_RECIP_LO};
        n_ph   = {20'b0, r_s2_yff} * {31'b0, FF_RECIP_HI};
    end

    // stage 4: restore sign, scale negative demand, finish feedforward
    always_comb begin
        n_ffsum   = {r_s3_ph, 20'b0} + {20'b0, r_s3_pl};
        n_base    = r_s3_neg ? ~$signed({1'b0, r_s3_q}) : $signed({1'b0, r_s3_q});
        n_s4.acc0 = n_base[27] ? {n_base, 2'b00} : 30'(n_base);
        n_s4.ff   = n_ffsum[70:51];
        n_s4.ff_op = r_s3_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (w_rdy2) begin
                r_s2_vld <= i_vld;
            end
            if (w_rdy3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (w_rdy4) begin
                r_s4_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_y   <= n_u[33:2];
            r_s2_neg <= n_neg;
            r_s2_yff <= n_yff;
            r_s2_op  <= i_front.ff_op;
        end
        if (w_rdy3) begin
            r_s3_q   <= n_prod[62:36];
            r_s3_neg <= r_s2_neg;
            r_s3_pl  <= n_pl;
            r_s3_ph  <= n_ph;
            r_s3_op  <= r_s2_op;
        end
        if (w_rdy4) begin
            r_s4 <= n_s4;
        end
    end

    assign o_rdy   = w_rdy2;
    assign o_vld   = r_s4_vld;
    assign o_scale = r_s4;

endmodule

`default_nettype wire

>>> hw/rtl/pfal_limit.sv
// ---------------------------------------------------------------------------
// pfal_limit
// Stages five and six: apply feedforward, clamp against the limits and
// encode the command; stage six is the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfal_limit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfal_pkg::t_cfg      i_cfg,
    input  logic                i_vld,
    output logic                o_rdy,
    input  pfal_pkg::t_scale    i_scale,
    output logic                o_vld,
    input  logic                i_rdy,
    output pfal_pkg::t_out_item o_item
);
    import pfal_pkg::*;

    function automatic logic [8:0] milli_to_code(input logic signed [14:0] milli);
        logic signed [15:0] ofs;
        logic [31:0]        prod;
        logic [9:0]         q;
        ofs  = 16'(milli) + MILLI_OFFSET;
        prod = {17'b0, ofs[14:0]} * DIV100_RECIP;
        q    = prod[31:22];
        if (ofs[15]) begin
            milli_to_code = '0;
        end else if (q > {1'b0, CODE_MAX}) begin
            milli_to_code = CODE_MAX;
        end else begin
            milli_to_code = q[8:0];
        end
    endfunction

    logic               r_s5_vld;
    logic signed [31:0] r_s5_acc;
    logic               r_s6_vld;
    t_out_item          r_s6_item;

    logic               w_rdy5;
    logic               w_rdy6;
    logic signed [31:0] n_acc;
    logic signed [31:0] n_ff;
    logic signed [39:0] n_a125;
    logic signed [39:0] n_hi;
    logic signed [39:0] n_lo;
    logic signed [35:0] n_ofs;
    logic signed [35:0] n_t;
    logic [19:0]        n_tq;
    logic [8:0]         n_code_q;
    t_out_item          n_item;

    assign w_rdy6 = !r_s6_vld || i_rdy;
    assign w_rdy5 = !r_s5_vld || w_rdy6;

    always_comb begin
        n_ff = $signed({12'b0, i_scale.ff});
        unique case (i_scale.ff_op)
            FF_ADD:  n_acc = 32'(i_scale.acc0) + n_ff;
            FF_SUB:  n_acc = 32'(i_scale.acc0) - n_ff;
            default: n_acc = 32'(i_scale.acc0);
        endcase
    end

    always_comb begin
        n_a125 = (40'(r_s5_acc) <<< 7) - (40'(r_s5_acc) <<< 1) - 40'(r_s5_acc);
        n_hi   = 40'(i_cfg.accel_limit_milli) <<< 13;
        n_lo   = 40'(i_cfg.decel_limit_milli) <<< 13;
        n_ofs  = 36'(r_s5_acc) + ACC_OFFSET_Q;
        n_t    = (n_ofs <<< 3) + (n_ofs <<< 1);
        n_tq   = n_t[35:16];
        if (n_t[35]) begin
            n_code_q = '0;
        end else if (n_tq > {11'b0, CODE_MAX}) begin
            n_code_q = CODE_MAX;
        end else begin
            n_code_q = n_tq[8:0];
        end

        priority if (n_a125 > n_hi) begin
            n_item.accel_command_code = milli_to_code(i_cfg.accel_limit_milli);
            n_item.limited            = 1'b1;
        end else if (n_a125 < n_lo) begin
            n_item.accel_command_code = milli_to_code(i_cfg.decel_limit_milli);
            n_item.limited            = 1'b1;
        end else begin
            n_item.accel_command_code = n_code_q;
            n_item.limited            = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else begin
            if (w_rdy5) begin
                r_s5_vld <= i_vld;
            end
            if (w_rdy6) begin
                r_s6_vld <= r_s5_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_s5_acc <= n_acc;
        end
        if (w_rdy6) begin
            r_s6_item <= n_item;
        end
    end

    assign o_rdy  = w_rdy5;
    assign o_vld  = r_s6_vld;
    assign o_item = r_s6_item;

endmodule

`default_nettype wire

>>> hw/rtl/platoon_following_accel_law.sv
// ---------------------------------------------------------------------------
// platoon_following_accel_law
// Follower acceleration command from leader and follower state, six stages.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one sample per
// transfer; output channel (o_out_valid / i_out_ready / o_out_data) returns
// exactly one command per sample, in order.
// Throughput: one sample per cycle while i_out_ready stays high; the six
// registered stages each advance on their own, so bubbles close up and the
// input keeps taking samples while a finished command waits in the output
// register.
// If the receiver holds i_out_ready low, the output register holds its
// command and the stages behind it fill; o_in_ready drops once all six hold
// a sample. Nothing is dropped or repeated.
// Configuration: i_cfg_wr_en writes i_cfg_wdata to the register selected by
// i_cfg_index on the same edge; write only while the pipeline is empty.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the
// default gap, limits and gains.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module platoon_following_accel_law (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pfal_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pfal_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_wr_en,
    input  logic [pfal_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfal_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import pfal_pkg::*;

    t_cfg   r_cfg;

    logic   w_front_vld;
    logic   w_front_rdy;
    t_front w_front;
    logic   w_scale_vld;
    logic   w_scale_rdy;
    t_scale w_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IDX_DESIRED_GAP: r_cfg.desired_gap_cm    <= i_cfg_wdata;
                CFG_IDX_ACCEL_LIMIT: r_cfg.accel_limit_milli <= i_cfg_wdata[14:0];
                CFG_IDX_DECEL_LIMIT: r_cfg.decel_limit_milli <= i_cfg_wdata[14:0];
                CFG_IDX_GAIN_ACCEL:  r_cfg.gain_leader_accel <= i_cfg_wdata;
                CFG_IDX_GAIN_SPEED:  r_cfg.gain_speed_diff   <= i_cfg_wdata;
                CFG_IDX_GAIN_GAP:    r_cfg.gain_gap_error    <= i_cfg_wdata;
                default:             r_cfg                   <= r_cfg;
            endcase
        end
    end

    pfal_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (i_in_valid),
        .o_rdy   (o_in_ready),
        .i_item  (i_in_data),
        .o_vld   (w_front_vld),
        .i_rdy   (w_front_rdy),
        .o_front (w_front)
    );

    pfal_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .o_rdy   (w_front_rdy),
        .i_front (w_front),
        .o_vld   (w_scale_vld),
        .i_rdy   (w_scale_rdy),
        .o_scale (w_scale)
    );

    pfal_limit u_limit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (w_scale_vld),
        .o_rdy   (w_scale_rdy),
        .i_scale (w_scale),
        .o_vld   (o_out_valid),
        .i_rdy   (i_out_ready),
        .o_item  (o_out_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/pfal_checker.sv
// ---------------------------------------------------------------------------
// pfal_checker
// Port-level checks for the platoon following acceleration law block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "platoon_following_accel_law_assert.svh"

module pfal_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input pfal_pkg::t_out_item o_out_data
);
    import pfal_pkg::*;

    `PFAL_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
    `PFAL_ASSERT(a_code_range, i_clk, i_rst_n, o_out_valid |-> (o_out_data.accel_command_code <= CODE_MAX))
    `PFAL_ASSERT(a_ready_when_drained, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)
    `PFAL_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind platoon_following_accel_law pfal_checker u_pfal_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

>>> tb/pfal_accel_checker.sv
// ---------------------------------------------------------------------------
// pfal_accel_checker
// Watches the sample, command and register ports of the following law block,
// keeps its own copy of the gap, limits and gains, predicts the command for
// every accepted sample and compares each returned command in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfal_accel_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  pfal_pkg::t_in_item                  i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  pfal_pkg::t_out_item                 i_out_data,
    input  logic                                i_cfg_wr_en,
    input  logic [pfal_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfal_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    import pfal_pkg::*;

    localparam longint Q_ONE = 64'sd65536;

    t_cfg      law_cfg;
    t_out_item expected_commands[$];
    int        mismatches = 0;

    function automatic logic [8:0] milli_to_code(longint milli);
        longint x;
        x = milli + 15000;
        if (x < 0) begin
            return 9'd0;
        end
        x = x / 100;
        return (x > 300) ? 9'd300 : 9'(x);
    endfunction

    function automatic t_out_item predict_accel_command(t_in_item s, t_cfg c);
        longint    ga, gv, gd, da, dv, de, num, acc, brake, thr, hi, lo, t;
        t_out_item r;
        ga    = longint'(c.gain_leader_accel);
        gv    = longint'(c.gain_speed_diff);
        gd    = longint'(c.gain_gap_error);
        da    = longint'(s.leader_accel_code) - 150;
        dv    = longint'(s.leader_speed_code) - longint'(s.follower_speed_code);
        de    = longint'(s.gap_cm) - longint'(c.desired_gap_cm);
        brake = longint'(s.leader_brake_code);
        thr   = longint'(s.leader_throttle_code);
        hi    = longint'(c.accel_limit_milli);
        lo    = longint'(c.decel_limit_milli);

        if (de < 1000 && de > -500) begin
            num = 10 * ga * da + 10 * gv * dv + gd * de;
        end else begin
            num = 5 * ga * da + 5 * gv * dv + 2 * gd * de;
        end
        acc = num / 100;
        if (num % 100 != 0 && num < 0) begin
            acc = acc - 1;
        end
        if (acc < 0) begin
            acc = acc * 4;
        end

        if (brake > 20) begin
            if (brake > 1000 && brake < 5000) begin
                acc = acc - (Q_ONE * (180000 * brake + 24 * brake * brake)) / 1000000000;
            end else if (brake >= 5000) begin
                acc = acc - (Q_ONE * 3 * brake) / 10000;
            end
        end else if (thr > 1000) begin
            acc = acc + (Q_ONE * (120000 * thr + 12 * thr * thr)) / 1000000000;
        end

        r.limited = 1'b0;
        if (acc * 1000 > hi * Q_ONE) begin
            r.accel_command_code = milli_to_code(hi);
            r.limited            = 1'b1;
        end else if (acc * 1000 < lo * Q_ONE) begin
            r.accel_command_code = milli_to_code(lo);
            r.limited            = 1'b1;
        end else begin
            t = (acc + 15 * Q_ONE) * 10;
            if (t < 0) begin
                r.accel_command_code = 9'd0;
            end else begin
                t = t / Q_ONE;
                r.accel_command_code = (t > 300) ? 9'd300 : 9'(t);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            law_cfg = CFG_RESET;
            expected_commands.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_commands.size() == 0) begin
                    $display("%0t: command transfer with nothing outstanding: code %0d limited %0b",
                             $time, i_out_data.accel_command_code, i_out_data.limited);
                    mismatches++;
                end else begin
                    want = expected_commands.pop_front();
                    if (i_out_data.accel_command_code !== want.accel_command_code) begin
                        $display("%0t: accel_command_code expected %0d actual %0d",
                                 $time, want.accel_command_code,
                                 i_out_data.accel_command_code);
                        mismatches++;
                    end
                    if (i_out_data.limited !== want.limited) begin
                        $display("%0t: limited expected %0b actual %0b",
                                 $time, want.limited, i_out_data.limited);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_commands.push_back(predict_accel_command(i_in_data, law_cfg));
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_IDX_DESIRED_GAP: law_cfg.desired_gap_cm    = i_cfg_wdata;
                    CFG_IDX_ACCEL_LIMIT: law_cfg.accel_limit_milli = i_cfg_wdata[14:0];
                    CFG_IDX_DECEL_LIMIT: law_cfg.decel_limit_milli = i_cfg_wdata[14:0];
                    CFG_IDX_GAIN_ACCEL:  law_cfg.gain_leader_accel = i_cfg_wdata;
                    CFG_IDX_GAIN_SPEED:  law_cfg.gain_speed_diff   = i_cfg_wdata;
                    CFG_IDX_GAIN_GAP:    law_cfg.gain_gap_error    = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_commands.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the platoon following acceleration law block.
// Sends directed edge samples, then random samples under several gap, limit
// and gain settings with random idling on both channels and one long command
// back-pressure; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    import pfal_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_7 = 3'd7;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    t_in_item              in_data    = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    t_out_item             out_data;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  hold_burst = 1'b0;
    logic                  rx_idles   = 1'b1;
    int                    fail_count;
    int                    pending;
    int                    stall_cycles = 0;
    bit                    tx_idles = 1'b1;
    logic [15:0]           target_gap = CFG_RESET.desired_gap_cm;

    always #1 clk = ~clk;

    platoon_following_accel_law DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    pfal_accel_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_item sample_of(int ls, int fs, int ac, int gap, int br, int th);
        t_in_item s;
        s.leader_speed_code    = 12'(ls);
        s.follower_speed_code  = 12'(fs);
        s.leader_accel_code    = 9'(ac);
        s.gap_cm               = 16'(gap);
        s.leader_brake_code    = 14'(br);
        s.leader_throttle_code = 14'(th);
        return s;
    endfunction

    function automatic logic [13:0] random_pedal(int rest_weight);
        int sel;
        sel = int'($urandom_range(0, 99));
        if (sel < rest_weight) begin
            return 14'($urandom_range(0, 20));
        end
        sel = int'($urandom_range(0, 9));
        if (sel < 2) begin
            return 14'($urandom_range(21, 1000));
        end else if (sel < 5) begin
            return 14'($urandom_range(1001, 4999));
        end else if (sel < 8) begin
            return 14'($urandom_range(5000, 10000));
        end
        return 14'($urandom_range(10001, 16383));
    endfunction

    function automatic t_in_item random_sample(logic [15:0] target);
        t_in_item s;
        int       f;
        int       sel;
        s.leader_speed_code = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) < 7) begin
            f = int'(s.leader_speed_code) + int'($urandom_range(0, 120)) - 60;
            f = (f < 0) ? 0 : ((f > 4095) ? 4095 : f);
            s.follower_speed_code = 12'(f);
        end else begin
            s.follower_speed_code = 12'($urandom_range(0, 4095));
        end
        s.leader_accel_code = ($urandom_range(0, 9) < 9) ? 9'($urandom_range(0, 300))
                                                         : 9'($urandom_range(0, 511));
        sel = int'($urandom_range(0, 19));
        case (sel)
            0:       s.gap_cm = target + 16'd1000;
            1:       s.gap_cm = target - 16'd500;
            2:       s.gap_cm = target + 16'd999;
            3:       s.gap_cm = target - 16'd499;
            4, 5:    s.gap_cm = 16'($urandom_range(0, 65535));
            default: s.gap_cm = target + 16'(int'($urandom_range(0, 1900)) - 700);
        endcase
        s.leader_brake_code    = random_pedal(50);
        s.leader_throttle_code = random_pedal(20);
        return s;
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        c.desired_gap_cm    = 16'($urandom_range(0, 65535));
        c.accel_limit_milli = 15'(int'($urandom_range(0, 30000)) - 15000);
        c.decel_limit_milli = 15'(int'($urandom_range(0, 30000)) - 15000);
        c.gain_leader_accel = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                          : 16'($urandom_range(0, 8000));
        c.gain_speed_diff   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                          : 16'($urandom_range(0, 8000));
        c.gain_gap_error    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                          : 16'($urandom_range(0, 8000));
        return c;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic load_law_settings(t_cfg c);
        write_reg(CFG_IDX_DESIRED_GAP, c.desired_gap_cm);
        write_reg(CFG_IDX_ACCEL_LIMIT, {1'($urandom_range(0, 1)), c.accel_limit_milli});
        write_reg(CFG_IDX_DECEL_LIMIT, {1'($urandom_range(0, 1)), c.decel_limit_milli});
        write_reg(CFG_IDX_GAIN_ACCEL, c.gain_leader_accel);
        write_reg(CFG_IDX_GAIN_SPEED, c.gain_speed_diff);
        write_reg(CFG_IDX_GAIN_GAP, c.gain_gap_error);
        cfg_wr_en  <= 1'b0;
        target_gap  = c.desired_gap_cm;
    endtask

    task automatic send_sample(t_in_item s);
        while (tx_idles && $urandom_range(0, 99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random(int count);
        repeat (count) send_sample(random_sample(target_gap));
    endtask

    task automatic wait_commands_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // command side: random idling, one long holdoff on request
    initial begin : rx_proc
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_burst && !hold_done) begin
                hold_left = HOLDOFF_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= !(rx_idles && $urandom_range(0, 99) < 6);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edges of the fields, bands, pedal branches and demand sign
        send_sample(sample_of(0, 0, 0, 0, 0, 0));
        send_sample(sample_of(4095, 4095, 511, 65535, 16383, 16383));
        send_sample(sample_of(4095, 0, 300, 1500, 0, 0));
        send_sample(sample_of(0, 4095, 0, 1500, 0, 0));
        send_sample(sample_of(200, 200, 150, 1500, 0, 0));
        send_sample(sample_of(200, 198, 150, 2500, 0, 0));
        send_sample(sample_of(200, 198, 150, 2499, 0, 0));
        send_sample(sample_of(200, 198, 150, 1000, 0, 0));
        send_sample(sample_of(200, 198, 150, 1001, 0, 0));
        send_sample(sample_of(200, 203, 148, 1500, 0, 0));
        send_sample(sample_of(200, 200, 150, 1500, 20, 2000));
        send_sample(sample_of(200, 200, 150, 1500, 21, 2000));
        send_sample(sample_of(200, 200, 150, 1500, 1000, 0));
        send_sample(sample_of(200, 200, 150, 1500, 1001, 0));
        send_sample(sample_of(200, 200, 150, 1500, 4999, 0));
        send_sample(sample_of(200, 200, 150, 1500, 5000, 0));
        send_sample(sample_of(200, 200, 150, 1500, 10000, 0));
        send_sample(sample_of(200, 200, 150, 1500, 16383, 0));
        send_sample(sample_of(200, 200, 150, 1500, 0, 1000));
        send_sample(sample_of(200, 200, 150, 1500, 0, 1001));
        send_sample(sample_of(200, 200, 150, 1500, 0, 10000));
        send_sample(sample_of(200, 200, 150, 1500, 0, 16383));
        send_sample(sample_of(200, 200, 511, 1500, 0, 0));

        send_random(50);
        hold_burst <= 1'b1;
        send_random(150);
        wait_commands_drained();

        load_law_settings('{desired_gap_cm:    16'd0,
                            accel_limit_milli: 15'sd15000,
                            decel_limit_milli: -15'sd15000,
                            gain_leader_accel: 16'hFFFF,
                            gain_speed_diff:   16'hFFFF,
                            gain_gap_error:    16'hFFFF});
        send_random(200);
        wait_commands_drained();

        // crossed limits: upper one wins
        load_law_settings('{desired_gap_cm:    16'hFFFF,
                            accel_limit_milli: -15'sd3000,
                            decel_limit_milli: 15'sd2000,
                            gain_leader_accel: 16'd0,
                            gain_speed_diff:   16'd0,
                            gain_gap_error:    16'd0});
        send_random(150);
        wait_commands_drained();

        // widest limits: code saturates without clamping; no idling here
        tx_idles  = 1'b0;
        rx_idles <= 1'b0;
        load_law_settings('{desired_gap_cm:    16'd1500,
                            accel_limit_milli: 15'h3FFF,
                            decel_limit_milli: 15'h4000,
                            gain_leader_accel: 16'd6554,
                            gain_speed_diff:   16'd3277,
                            gain_gap_error:    16'd3277});
        send_random(200);
        wait_commands_drained();
        tx_idles  = 1'b1;
        rx_idles <= 1'b1;

        repeat (4) begin
            load_law_settings(random_settings());
            write_reg(CFG_IDX_SPARE_6, 16'($urandom_range(0, 65535)));
            write_reg(CFG_IDX_SPARE_7, 16'($urandom_range(0, 65535)));
            cfg_wr_en <= 1'b0;
            send_random(200);
            wait_commands_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
